/* rtl/chained_hash_table_core_defines.svh */
//------------------------------------------------------------------------------
// Chained hash table assertion macros
// Shared concurrent assertion forms used by the hash table RTL.
//------------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CHT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CHT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* rtl/cht_pkg.sv */
//------------------------------------------------------------------------------
// Chained hash table package
// Field widths, operation codes and result status codes.
//------------------------------------------------------------------------------
`default_nettype none

package cht_pkg;

   localparam int KeyWidth       = 31;
   localparam int StatusWidth    = 3;
   localparam int BucketOutWidth = 3;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef enum logic [StatusWidth-1:0] {
      STATUS_INSERTED  = 3'd0,
      STATUS_DELETED   = 3'd1,
      STATUS_EMPTY     = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_POOL_FULL = 3'd4
   } status_type;

endpackage

`default_nettype wire

/* rtl/chained_hash_table_core.sv */
//------------------------------------------------------------------------------
// Chained hash table core
// Hash table with separate chaining over a fixed node pool: inserts append at
// the tail of a bucket chain, deletes unlink the first matching node.
//
//   Channel   Ports                                  Transfer
//   command   start, busy, req_kind, req_key_value   start high while busy low
//   result    rsp_strobe, rsp_status,                one cycle with rsp_strobe
//             rsp_bucket_index                        high
//
// The front end takes each command through accept, eight remainder steps of four
// key bits and a queue write, holding the write while the two-entry queue is full.
// The engine walks chains one node per cycle: a pool-full insert or empty-chain
// delete ends at the head lookup, other inserts allocate, link and walk to the tail,
// and deletes compare the head, then walk later nodes and free a later match.
// Reset is synchronous; results cannot be held off by the receiver.
//------------------------------------------------------------------------------
`default_nettype none

module chained_hash_table_core
   import cht_pkg::*;
#(
   parameter int NUM_BUCKETS = 8,
   parameter int POOL_DEPTH  = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic                      req_kind,
   input  wire logic [KeyWidth-1:0]       req_key_value,
   output logic                           rsp_strobe,
   output logic [StatusWidth-1:0]         rsp_status,
   output logic [BucketOutWidth-1:0]      rsp_bucket_index
);

   localparam int BucketWidth = $clog2(NUM_BUCKETS);
   localparam int ItemWidth   = 1 + KeyWidth + BucketWidth;

   logic                   push;
   logic [ItemWidth-1:0]   push_data;
   logic                   queue_full;
   logic                   pop;
   logic [ItemWidth-1:0]   pop_data;
   logic                   queue_empty;

   cht_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_key_value (req_key_value),
      .push          (push),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   cht_fifo #(.WIDTH(ItemWidth)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   cht_back #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_DEPTH(POOL_DEPTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (queue_empty),
      .pop              (pop),
      .item_kind        (pop_data[ItemWidth-1]),
      .item_key         (pop_data[ItemWidth-2 -: KeyWidth]),
      .item_bucket      (pop_data[BucketWidth-1:0]),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

`default_nettype wire

/* rtl/cht_ram.sv */
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/cht_fifo.sv */
//------------------------------------------------------------------------------
// Chained hash table item queue
// Two-entry queue between the hashing front end and the table engine.
//------------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_table_core_defines.svh"

module cht_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `CHT_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full, "queue written while full")

endmodule

`default_nettype wire

/* rtl/cht_front.sv */
//------------------------------------------------------------------------------
// Chained hash table front end
// Accepts a command, reduces its key modulo the bucket count four bits per
// cycle and hands the classified item to the queue.
//------------------------------------------------------------------------------
`default_nettype none

module cht_front
   import cht_pkg::*;
#(
   parameter int NUM_BUCKETS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_kind,
   input  wire logic [KeyWidth-1:0]                req_key_value,
   output logic                                    push,
   output logic [KeyWidth+$clog2(NUM_BUCKETS):0]   push_data,
   input  wire logic                               queue_full
);

   localparam int RemWidth   = $clog2(NUM_BUCKETS);
   localparam int DigitBits  = 4;
   localparam int ShiftWidth = 32;
   localparam int NumDigits  = ShiftWidth / DigitBits;
   localparam int CountWidth = $clog2(NumDigits);
   localparam logic [RemWidth:0] Modulus = (RemWidth + 1)'(NUM_BUCKETS);
   localparam logic [CountWidth-1:0] LastDigit = CountWidth'(NumDigits - 1);

   typedef enum logic [2:0] {
      FS_IDLE   = 3'b001,
      FS_REDUCE = 3'b010,
      FS_PUSH   = 3'b100
   } front_state_type;

   front_state_type         state_ff, state_in;
   logic                    kind_ff, kind_in;
   logic [KeyWidth-1:0]     key_ff, key_in;
   logic [ShiftWidth-1:0]   shift_ff, shift_in;
   logic [RemWidth-1:0]     rem_ff, rem_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [RemWidth-1:0]     rem_step;
   logic [RemWidth:0]       rem_wide;

   // Remainder update over the next four key bits, most significant first.
   always_comb begin
      rem_step = rem_ff;
      rem_wide = '0;
      for (int i = 0; i < DigitBits; i++) begin
         rem_wide = {rem_step, shift_ff[ShiftWidth-1-i]};
         if (rem_wide >= Modulus) begin
            rem_wide = rem_wide - Modulus;
         end
         rem_step = rem_wide[RemWidth-1:0];
      end
   end

   assign busy      = (state_ff != FS_IDLE);
   assign push      = (state_ff == FS_PUSH) && !queue_full;
   assign push_data = {kind_ff, key_ff, rem_ff};

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      case (state_ff)
         FS_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               key_in   = req_key_value;
               shift_in = {1'b0, req_key_value};
               rem_in   = '0;
               count_in = '0;
               state_in = FS_REDUCE;
            end
         end
         FS_REDUCE: begin
            rem_in   = rem_step;
            shift_in = {shift_ff[ShiftWidth-DigitBits-1:0], {DigitBits{1'b0}}};
            count_in = count_ff + 1'b1;
            if (count_ff == LastDigit) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!queue_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

/* rtl/cht_back.sv */
//------------------------------------------------------------------------------
// Chained hash table engine
// Takes queued items and carries out inserts and deletes on the bucket heads
// and the node pool, walking each chain one node per cycle.
//------------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_table_core_defines.svh"

module cht_back
   import cht_pkg::*;
#(
   parameter int NUM_BUCKETS = 8,
   parameter int POOL_DEPTH  = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             empty,
   output logic                                  pop,
   input  wire logic                             item_kind,
   input  wire logic [KeyWidth-1:0]              item_key,
   input  wire logic [$clog2(NUM_BUCKETS)-1:0]   item_bucket,
   output logic                                  rsp_strobe,
   output logic [StatusWidth-1:0]                rsp_status,
   output logic [BucketOutWidth-1:0]             rsp_bucket_index
);

   localparam int BucketWidth = $clog2(NUM_BUCKETS);
   localparam int AddrWidth   = $clog2(POOL_DEPTH);
   localparam int IdWidth     = $clog2(POOL_DEPTH + 1);
   localparam int ExtWidth    = (BucketWidth > BucketOutWidth) ? BucketWidth : BucketOutWidth;
   localparam logic [IdWidth-1:0] NullId = IdWidth'(POOL_DEPTH);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_HEAD  = 8'b0000_0010,
      ST_ALLOC = 8'b0000_0100,
      ST_LINK  = 8'b0000_1000,
      ST_WALK  = 8'b0001_0000,
      ST_DHEAD = 8'b0010_0000,
      ST_DWALK = 8'b0100_0000,
      ST_DFREE = 8'b1000_0000
   } back_state_type;

   back_state_type            state_ff, state_in;
   logic                      kind_ff, kind_in;
   logic [KeyWidth-1:0]       key_ff, key_in;
   logic [BucketWidth-1:0]    bucket_ff, bucket_in;
   logic [IdWidth-1:0]        head_ff, head_in;
   logic [IdWidth-1:0]        new_ff, new_in;
   logic [IdWidth-1:0]        p_ff, p_in;
   logic [IdWidth-1:0]        q_ff, q_in;
   logic [IdWidth-1:0]        steps_ff, steps_in;
   logic [IdWidth-1:0]        free_head_ff, free_head_in;
   logic [IdWidth-1:0]        unused_ff, unused_in;
   logic [NUM_BUCKETS-1:0]    head_valid_ff, head_valid_in;
   logic                      rsp_strobe_ff, rsp_strobe_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [BucketOutWidth-1:0] rsp_bucket_ff, rsp_bucket_in;

   logic                      bkt_we;
   logic [IdWidth-1:0]        bkt_wdata;
   logic [IdWidth-1:0]        bkt_rdata;
   logic                      val_we;
   logic [KeyWidth-1:0]       val_rdata;
   logic                      next_we;
   logic [IdWidth-1:0]        next_waddr;
   logic [IdWidth-1:0]        next_wdata;
   logic [IdWidth-1:0]        next_rdata;
   logic [IdWidth-1:0]        node_raddr;

   logic [IdWidth-1:0]        head_id;
   logic                      head_is_node;
   logic                      next_is_node;
   logic                      free_is_node;
   logic [IdWidth-1:0]        steps_inc;
   logic [ExtWidth-1:0]       bucket_ext;
   logic                      pool_in_range;

   cht_ram #(.WIDTH(IdWidth), .DEPTH(NUM_BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_we),
      .wr_addr (bucket_ff),
      .wr_data (bkt_wdata),
      .rd_addr (item_bucket),
      .rd_data (bkt_rdata)
   );

   cht_ram #(.WIDTH(KeyWidth), .DEPTH(POOL_DEPTH)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (new_ff[AddrWidth-1:0]),
      .wr_data (key_ff),
      .rd_addr (node_raddr[AddrWidth-1:0]),
      .rd_data (val_rdata)
   );

   cht_ram #(.WIDTH(IdWidth), .DEPTH(POOL_DEPTH)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr[AddrWidth-1:0]),
      .wr_data (next_wdata),
      .rd_addr (node_raddr[AddrWidth-1:0]),
      .rd_data (next_rdata)
   );

   // A bucket that was never written reads as an empty chain.
   assign head_id      = head_valid_ff[bucket_ff] ? bkt_rdata : NullId;
   assign head_is_node = (head_id < NullId);
   assign next_is_node = (next_rdata < NullId);
   assign free_is_node = (free_head_ff < NullId);
   assign steps_inc    = steps_ff + 1'b1;
   assign bucket_ext   = ExtWidth'(bucket_ff);
   assign pool_in_range = (unused_ff <= NullId) && (free_head_ff <= NullId);

   assign pop              = (state_ff == ST_IDLE) && !empty;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_bucket_ff;

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      bucket_in     = bucket_ff;
      head_in       = head_ff;
      new_in        = new_ff;
      p_in          = p_ff;
      q_in          = q_ff;
      steps_in      = steps_ff;
      free_head_in  = free_head_ff;
      unused_in     = unused_ff;
      head_valid_in = head_valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = bucket_ext[BucketOutWidth-1:0];
      bkt_we        = 1'b0;
      bkt_wdata     = new_ff;
      val_we        = 1'b0;
      next_we       = 1'b0;
      next_waddr    = new_ff;
      next_wdata    = NullId;
      node_raddr    = free_head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               kind_in   = item_kind;
               key_in    = item_key;
               bucket_in = item_bucket;
               state_in  = ST_HEAD;
            end
         end
         ST_HEAD: begin
            head_in = head_id;
            if (kind_ff == KIND_INSERT) begin
               if (free_is_node) begin
                  node_raddr = free_head_ff;
                  state_in   = ST_ALLOC;
               end else if (unused_ff < NullId) begin
                  new_in    = unused_ff;
                  unused_in = unused_ff + 1'b1;
                  state_in  = ST_LINK;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_POOL_FULL;
                  state_in      = ST_IDLE;
               end
            end else begin
               if (!head_is_node) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STATUS_EMPTY;
                  state_in      = ST_IDLE;
               end else begin
                  node_raddr = head_id;
                  p_in       = head_id;
                  state_in   = ST_DHEAD;
               end
            end
         end
         ST_ALLOC: begin
            new_in       = free_head_ff;
            free_head_in = next_rdata;
            state_in     = ST_LINK;
         end
         ST_LINK: begin
            val_we     = 1'b1;
            next_we    = 1'b1;
            next_waddr = new_ff;
            next_wdata = NullId;
            if (head_ff >= NullId) begin
               bkt_we                   = 1'b1;
               bkt_wdata                = new_ff;
               head_valid_in[bucket_ff] = 1'b1;
               rsp_strobe_in            = 1'b1;
               rsp_status_in            = STATUS_INSERTED;
               state_in                 = ST_IDLE;
            end else begin
               p_in       = head_ff;
               steps_in   = '0;
               node_raddr = head_ff;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            // Follow links to the tail; the step bound caps a corrupted chain.
            if (next_is_node && (steps_ff < NullId)) begin
               p_in       = next_rdata;
               node_raddr = next_rdata;
               steps_in   = steps_inc;
            end else begin
               next_we       = 1'b1;
               next_waddr    = p_ff;
               next_wdata    = new_ff;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_INSERTED;
               state_in      = ST_IDLE;
            end
         end
         ST_DHEAD: begin
            if (val_rdata == key_ff) begin
               bkt_we        = 1'b1;
               bkt_wdata     = next_rdata;
               next_we       = 1'b1;
               next_waddr    = p_ff;
               next_wdata    = free_head_ff;
               free_head_in  = p_ff;
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_DELETED;
               state_in      = ST_IDLE;
            end else if (next_is_node) begin
               q_in       = next_rdata;
               node_raddr = next_rdata;
               steps_in   = '0;
               state_in   = ST_DWALK;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end
         end
         ST_DWALK: begin
            if (val_rdata == key_ff) begin
               // Unlink here; the freed node is pushed on the free list next cycle.
               next_we    = 1'b1;
               next_waddr = p_ff;
               next_wdata = next_rdata;
               state_in   = ST_DFREE;
            end else if (next_is_node && (steps_inc < NullId)) begin
               p_in       = q_ff;
               q_in       = next_rdata;
               node_raddr = next_rdata;
               steps_in   = steps_inc;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
               state_in      = ST_IDLE;
            end
         end
         ST_DFREE: begin
            next_we       = 1'b1;
            next_waddr    = q_ff;
            next_wdata    = free_head_ff;
            free_head_in  = q_ff;
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_DELETED;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= NullId;
         unused_ff     <= '0;
         head_valid_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         unused_ff     <= unused_in;
         head_valid_ff <= head_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      bucket_ff     <= bucket_in;
      head_ff       <= head_in;
      new_ff        <= new_in;
      p_ff          <= p_in;
      q_ff          <= q_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
   end

   `CHT_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "strobe repeated")
   `CHT_ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, !empty, "queue read while empty")
   `CHT_ASSERT_IMPLY(a_pool_bound, clock, reset, 1'b1, pool_in_range, "pool pointer out of range")

endmodule

`default_nettype wire

/* bench/chained_hash_table_core_tb.sv */
//------------------------------------------------------------------------------
// Chained hash table core testbench
// Drives insert and delete commands into the core and checks every result
// against a tracker of the bucket chains, free list and node pool. Directed
// commands cover the chain cases first. Random phases then fill the pool to
// full and drain it again, with random idle cycles on the command side.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chained_hash_table_core_tb
   import cht_pkg::*;
;

   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 200;
   localparam int IdlePercent = 29;

   typedef struct {
      logic                      kind;
      logic [KeyWidth-1:0]       key;
      status_type                status;
      logic [BucketOutWidth-1:0] bucket;
   } chain_outcome_type;

   // Tracks the contents of the hash table and the results it must produce.
   class chain_table_tracker_type;
      localparam int NumBuckets = 8;
      localparam int PoolDepth  = 64;
      localparam bit [6:0] NullLink = 7'd64;

      bit [6:0]          head_link [NumBuckets];
      bit [KeyWidth-1:0] slot_key [PoolDepth];
      bit [6:0]          slot_link [PoolDepth];
      bit [6:0]          free_link;
      bit [6:0]          slots_handed_out;
      chain_outcome_type pending_outcomes [$];
      int                mismatch_count;

      function new();
         foreach (head_link[i]) head_link[i] = NullLink;
         foreach (slot_key[i]) slot_key[i] = '0;
         foreach (slot_link[i]) slot_link[i] = '0;
         free_link = NullLink;
         slots_handed_out = '0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return pending_outcomes.size();
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      // Applies one accepted command to the table and queues its result.
      function void note_command(logic kind, logic [KeyWidth-1:0] key);
         chain_outcome_type outcome;
         bit [2:0]       bkt;
         bit [6:0]       slot;
         bit [6:0]       walk;
         bit [6:0]       nxt;
         int             steps;
         bkt = key[2:0];
         outcome.kind = kind;
         outcome.key = key;
         outcome.bucket = bkt;
         if (kind == KIND_INSERT) begin
            if (free_link != NullLink) begin
               slot = free_link;
               free_link = slot_link[slot];
            end else if (slots_handed_out < PoolDepth) begin
               slot = slots_handed_out;
               slots_handed_out++;
            end else begin
               slot = NullLink;
            end
            if (slot == NullLink) begin
               outcome.status = STATUS_POOL_FULL;
            end else begin
               slot_key[slot] = key;
               slot_link[slot] = NullLink;
               if (head_link[bkt] == NullLink) begin
                  head_link[bkt] = slot;
               end else begin
                  walk = head_link[bkt];
                  steps = 0;
                  while (slot_link[walk] != NullLink && steps < PoolDepth) begin
                     walk = slot_link[walk];
                     steps++;
                  end
                  slot_link[walk] = slot;
               end
               outcome.status = STATUS_INSERTED;
            end
         end else begin
            walk = head_link[bkt];
            if (walk == NullLink) begin
               outcome.status = STATUS_EMPTY;
            end else if (slot_key[walk] == key) begin
               head_link[bkt] = slot_link[walk];
               slot_link[walk] = free_link;
               free_link = walk;
               outcome.status = STATUS_DELETED;
            end else begin
               outcome.status = STATUS_NOT_FOUND;
               steps = 0;
               while (slot_link[walk] != NullLink && steps < PoolDepth) begin
                  nxt = slot_link[walk];
                  if (slot_key[nxt] == key) begin
                     slot_link[walk] = slot_link[nxt];
                     slot_link[nxt] = free_link;
                     free_link = nxt;
                     outcome.status = STATUS_DELETED;
                     break;
                  end
                  walk = nxt;
                  steps++;
               end
            end
         end
         pending_outcomes.push_back(outcome);
      endfunction

      task check_outcome(logic [StatusWidth-1:0] status, logic [BucketOutWidth-1:0] bucket);
         chain_outcome_type exp;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result status=%0d bucket=%0d with nothing expected",
                             status, bucket));
         end else begin
            exp = pending_outcomes.pop_front();
            if (status !== exp.status)
               report($sformatf("kind=%0d key=%h: status %0d, expected %s",
                                exp.kind, exp.key, status, exp.status.name()));
            if (bucket !== exp.bucket)
               report($sformatf("kind=%0d key=%h: bucket %0d, expected %0d",
                                exp.kind, exp.key, bucket, exp.bucket));
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_kind;
   logic [KeyWidth-1:0]       req_key_value;
   logic                      rsp_strobe;
   logic [StatusWidth-1:0]    rsp_status;
   logic [BucketOutWidth-1:0] rsp_bucket_index;

   chain_table_tracker_type table_tracker = new();
   int                      cycle_count = 0;
   logic [KeyWidth-1:0]     key_set [24];

   chained_hash_table_core #(
      .NUM_BUCKETS(8),
      .POOL_DEPTH(64)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_key_value(req_key_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_bucket_index(rsp_bucket_index)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) table_tracker.check_outcome(rsp_status, rsp_bucket_index);
   end

   // Called at a falling edge; returns at the falling edge after the transfer, or after any idle cycles that follow it.
   task automatic send_command(logic kind, logic [KeyWidth-1:0] key, bit idle_on);
      start = 1'b1;
      req_kind = kind;
      req_key_value = key;
      @(posedge clock);
      while (busy) @(posedge clock);
      table_tracker.note_command(kind, key);
      @(negedge clock);
      if (idle_on) begin
         while ($urandom_range(99) < IdlePercent) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      start = 1'b0;
      while (table_tracker.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(int count, int insert_percent, bit idle_on);
      logic                kind;
      logic [KeyWidth-1:0] key;
      int                  k;
      for (k = 0; k < count; k++) begin
         kind = ($urandom_range(99) < insert_percent) ? KIND_INSERT : KIND_DELETE;
         if ($urandom_range(99) < 70) begin
            key = key_set[$urandom_range(23)];
         end else begin
            key = KeyWidth'($urandom());
            // About half of the fresh insert values join the working set so later deletes can find them.
            if (kind == KIND_INSERT && $urandom_range(1) == 1)
               key_set[$urandom_range(23)] = key;
         end
         send_command(kind, key, idle_on);
         if ($urandom_range(99) == 0) wait_drained();
      end
   endtask

   initial begin
      logic [KeyWidth-1:0] seed_key;
      int                  i;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_INSERT;
      req_key_value = '0;
      for (i = 0; i < 24; i++) begin
         seed_key = KeyWidth'($urandom());
         seed_key[2:0] = i[2:0];
         key_set[i] = seed_key;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Chain cases on bucket zero: empty, append, miss, middle, head, sole node, empty again.
      send_command(KIND_DELETE, 31'd0, 1'b1);
      send_command(KIND_INSERT, 31'd0, 1'b1);
      send_command(KIND_INSERT, 31'd8, 1'b1);
      send_command(KIND_INSERT, 31'd16, 1'b1);
      send_command(KIND_DELETE, 31'd24, 1'b1);
      send_command(KIND_DELETE, 31'd8, 1'b1);
      send_command(KIND_DELETE, 31'd0, 1'b1);
      send_command(KIND_DELETE, 31'd16, 1'b1);
      send_command(KIND_DELETE, 31'd16, 1'b1);
      // Largest values, duplicates in one chain, and reuse of freed nodes.
      send_command(KIND_INSERT, 31'h7FFF_FFFF, 1'b1);
      send_command(KIND_INSERT, 31'h7FFF_FFF7, 1'b1);
      send_command(KIND_INSERT, 31'h7FFF_FFFF, 1'b1);
      send_command(KIND_DELETE, 31'h7FFF_FFFF, 1'b1);
      send_command(KIND_DELETE, 31'h7FFF_FFFF, 1'b1);
      send_command(KIND_DELETE, 31'h7FFF_FFF7, 1'b1);
      send_command(KIND_INSERT, 31'h5555_5555, 1'b0);
      send_command(KIND_INSERT, 31'h2AAA_AAAA, 1'b0);
      send_command(KIND_INSERT, 31'h0000_0003, 1'b0);
      send_command(KIND_DELETE, 31'h2AAA_AAAA, 1'b0);
      send_command(KIND_DELETE, 31'h5555_5555, 1'b1);
      send_command(KIND_DELETE, 31'h0000_000B, 1'b1);
      wait_drained();

      run_phase(250, 50, 1'b1);
      wait_drained();
      // Mostly inserts with no idle cycles, enough to run the pool out of nodes.
      run_phase(200, 85, 1'b0);
      wait_drained();
      run_phase(150, 20, 1'b1);
      run_phase(100, 50, 1'b1);

      wait_drained();
      repeat (SettleCycles) @(posedge clock);
      if (table_tracker.mismatch_count == 0 && table_tracker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_fifo.sv
rtl/cht_front.sv
rtl/cht_back.sv
rtl/chained_hash_table_core.sv
bench/chained_hash_table_core_tb.sv
